### design/gcpv_pkg.sv
// Package for the command packet validator: reason codes, opcode codes
// and the record passed from the capture front to the check back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gcpv_pkg;

    localparam logic [2:0] R_OK    = 3'd0;
    localparam logic [2:0] R_HDR   = 3'd1;
    localparam logic [2:0] R_UNSUP = 3'd2;
    localparam logic [2:0] R_GFX   = 3'd3;
    localparam logic [2:0] R_SIZE  = 3'd4;
    localparam logic [2:0] R_FIELD = 3'd5;

    localparam logic [7:0] OP_NOP  = 8'h10;
    localparam logic [7:0] OP_11   = 8'h11;
    localparam logic [7:0] OP_12   = 8'h12;
    localparam logic [7:0] OP_13   = 8'h13;
    localparam logic [7:0] OP_15   = 8'h15;
    localparam logic [7:0] OP_16   = 8'h16;
    localparam logic [7:0] OP_26   = 8'h26;
    localparam logic [7:0] OP_2A   = 8'h2a;
    localparam logic [7:0] OP_2D   = 8'h2d;
    localparam logic [7:0] OP_2F   = 8'h2f;
    localparam logic [7:0] OP_35   = 8'h35;
    localparam logic [7:0] OP_37   = 8'h37;
    localparam logic [7:0] OP_40   = 8'h40;
    localparam logic [7:0] OP_42   = 8'h42;
    localparam logic [7:0] OP_46   = 8'h46;
    localparam logic [7:0] OP_50   = 8'h50;
    localparam logic [7:0] OP_58   = 8'h58;
    localparam logic [7:0] OP_63   = 8'h63;
    localparam logic [7:0] OP_64   = 8'h64;
    localparam logic [7:0] OP_69   = 8'h69;
    localparam logic [7:0] OP_76   = 8'h76;
    localparam logic [7:0] OP_79   = 8'h79;
    localparam logic [7:0] OP_7A   = 8'h7a;
    localparam logic [7:0] OP_81   = 8'h81;
    localparam logic [7:0] OP_83   = 8'h83;
    localparam logic [7:0] OP_9F   = 8'h9f;

    localparam logic [14:0] COUNT_MAX = 15'h7fff;

    // Number of payload words kept per packet.
    localparam int HELD_WORDS = 7;

    // One finished packet as captured by the front.
    typedef struct packed {
        logic [31:0]                 header;
        logic [HELD_WORDS-1:0][31:0] pw;       // payload words 1..HELD_WORDS
        logic [31:0]                 final_word;
        logic [14:0]                 count;
        logic                        zero_byte;
        logic                        tail_zero;
        logic                        cq;
    } t_packet;

endpackage
`default_nettype wire

### design/gcpv_front.sv
// Capture front of the command packet validator: collects words of a
// packet and emits one packet record on the last word. Uses gcpv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcpv_front
    import gcpv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_word,
    input  wire logic        i_last,
    input  wire logic        i_cq,
    input  wire logic        i_accept,
    output t_packet          o_pkt,
    output logic             o_pkt_valid
);

    localparam int IW = $clog2(HELD_WORDS);

    logic [31:0]                 r_header;
    logic [HELD_WORDS-1:0][31:0] r_held;
    logic [14:0]                 r_count;
    logic                        r_zero_byte;
    logic                        r_tail_zero;

    logic       w_zb;
    logic       w_zb_n;
    logic       w_tz_n;
    logic [31:0] w_hdr;
    logic [HELD_WORDS-1:0][31:0] w_held;

    assign w_zb = (i_word[7:0] == 8'd0) || (i_word[15:8] == 8'd0) ||
                  (i_word[23:16] == 8'd0) || (i_word[31:24] == 8'd0);

    always_comb begin
        w_hdr  = (r_count == 15'd0) ? i_word : r_header;
        w_held = r_held;
        for (int k = 0; k < HELD_WORDS; k++) begin
            if (r_count == 15'(k + 1)) begin
                w_held[IW'(k)] = i_word;
            end
        end
        w_zb_n = r_zero_byte || ((r_count != 15'd0) && w_zb);
        w_tz_n = r_tail_zero && !((r_count >= 15'd2) && (i_word != 32'd0));
    end

    always_comb begin
        o_pkt.header     = w_hdr;
        for (int k = 0; k < HELD_WORDS; k++) begin
            o_pkt.pw[k] = w_held[k];
        end
        o_pkt.final_word = i_word;
        o_pkt.count      = (r_count == COUNT_MAX) ? r_count : r_count + 15'd1;
        o_pkt.zero_byte  = w_zb_n;
        o_pkt.tail_zero  = w_tz_n;
        o_pkt.cq         = i_cq;
    end

    assign o_pkt_valid = i_accept && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_zero_byte <= 1'b0;
            r_tail_zero <= 1'b1;
        end else if (i_accept) begin
            if (i_last) begin
                r_count     <= '0;
                r_zero_byte <= 1'b0;
                r_tail_zero <= 1'b1;
            end else begin
                r_count     <= o_pkt.count;
                r_zero_byte <= w_zb_n;
                r_tail_zero <= w_tz_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_header <= w_hdr;
            r_held   <= w_held;
        end
    end

endmodule
`default_nettype wire

### design/gcpv_queue.sv
// Two-entry queue of packet records between the capture front and the
// check back end. Uses gcpv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcpv_queue
    import gcpv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_packet   i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_packet   o_data,
    output logic      o_valid
);

    t_packet    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

### design/gcpv_check.sv
// Check back end: evaluates the ordered checks on one packet record and
// holds the verdict in an output register. Uses gcpv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcpv_check
    import gcpv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_packet         i_pkt,
    input  wire logic       i_pkt_valid,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_accepted,
    output logic [2:0]      o_reason,
    output logic [7:0]      o_opcode
);

    function automatic logic [2:0] f_nop(input t_packet p);
        logic [5:0]  sub;
        logic [14:0] n;
        logic [2:0]  r;
        sub = p.header[7:2];
        n   = p.count;
        r   = R_OK;
        if (p.header[1:0] != 2'd0) r = R_UNSUP;
        else begin
            unique case (sub)
                6'h00: r = (p.pw[0][31:16] == 16'h6875) ? R_FIELD : R_OK;
                6'h09: r = (n == 15'd2) ? R_OK : R_SIZE;
                6'h06: begin
                    if (p.cq) r = R_GFX;
                    else if (n != 15'd4) r = R_SIZE;
                    else r = (p.pw[2] == 32'd0) ? R_OK : R_FIELD;
                end
                6'h0b: r = p.zero_byte ? R_OK : R_FIELD;
                6'h17: begin
                    if (p.cq) r = R_GFX;
                    else r = (n == 15'd6) ? R_OK : R_SIZE;
                end
                6'h1a: begin
                    if (p.cq) r = R_GFX;
                    else if (n != 15'd3 && n != 15'd5) r = R_SIZE;
                    else if (p.pw[0] > 32'd3) r = R_FIELD;
                    else r = p.tail_zero ? R_OK : R_FIELD;
                end
                default: r = R_OK;
            endcase
        end
        return r;
    endfunction

    function automatic logic [2:0] f_op(input t_packet p);
        logic [31:0] h, p1, p6, mask, off;
        logic [7:0]  op;
        logic [14:0] n;
        logic        cq;
        logic [5:0]  et;
        logic [2:0]  ei;
        logic [3:0]  s, d;
        logic [40:0] base, bytes;
        logic [2:0]  r;
        h  = p.header;
        op = h[15:8];
        n  = p.count;
        cq = p.cq;
        p1 = p.pw[0];
        p6 = p.pw[5];
        r  = R_OK;
        mask = 32'd0;
        off = 32'd0;
        et = p1[5:0];
        ei = p1[10:8];
        s = 4'd0;
        d = 4'd0;
        base = 41'd0;
        bytes = 41'd0;
        case (op)
            OP_11: begin
                if (n != 15'd4) r = R_SIZE;
                else if (!(p1 == 32'd1 && p.pw[1][2:0] == 3'd0 && p.pw[2] <= 32'hffff))
                    r = R_FIELD;
                else if (!h[1] && cq) r = R_GFX;
            end
            OP_12, OP_2A: begin
                if (cq) r = R_GFX;
                else if (n != 15'd2) r = R_SIZE;
                else if (op == OP_12) r = (p1[31:4] == 28'd0) ? R_OK : R_FIELD;
                else r = (p1 <= 32'd3) ? R_OK : R_FIELD;
            end
            OP_13, OP_2F: begin
                if (cq) r = R_GFX;
                else r = (n == 15'd2) ? R_OK : R_SIZE;
            end
            OP_26: begin
                if (cq) r = R_GFX;
                else r = (n == 15'd3) ? R_OK : R_SIZE;
            end
            OP_2D: begin
                if (cq) r = R_GFX;
                else if (n != 15'd3) r = R_SIZE;
                else r = ((p.pw[1] & ~32'h20) == 32'd2) ? R_OK : R_FIELD;
            end
            OP_35: begin
                if (cq) r = R_GFX;
                else if (n != 15'd5) r = R_SIZE;
                else if (p.pw[2] > p1) r = R_FIELD;
                else r = ((p.pw[3] & ~32'h20) == 32'd0) ? R_OK : R_FIELD;
            end
            OP_15: begin
                if (n != 15'd5) r = R_SIZE;
                else r = ((p.pw[3] & ~32'h8000) == 32'h41) ? R_OK : R_FIELD;
            end
            OP_16: begin
                if (n != 15'd3 && n != 15'd4) r = R_SIZE;
                else r = ((p.final_word & ~32'h8000) == 32'h41) ? R_OK : R_FIELD;
            end
            OP_42: begin
                if (n != 15'd2) r = R_SIZE;
                else r = (p1 == 32'd0) ? R_OK : R_FIELD;
            end
            OP_46: begin
                if ((p1 & ~32'h73f) != 32'd0) r = R_FIELD;
                else if (et == 6'h07 || et == 6'h0f || et == 6'h10) begin
                    if (n != 15'd2) r = R_SIZE;
                    else if (ei != 3'd4) r = R_FIELD;
                    else if (et != 6'h07 && cq) r = R_GFX;
                end else if (et == 6'h16 || et == 6'h31 || et == 6'h2a ||
                             et == 6'h2c || et == 6'h2e) begin
                    if (cq) r = R_GFX;
                    else if (n != 15'd2) r = R_SIZE;
                    else r = (ei == 3'd0 || ei == 3'd7) ? R_OK : R_FIELD;
                end else r = R_FIELD;
            end
            OP_58: begin
                mask  = (n == 15'd8) ? 32'h86287fc3 : 32'hfeecfffb;
                base  = {1'b0, p.pw[3], 8'd0};
                bytes = {1'b0, p.pw[1], 8'd0};
                if (n != 15'd7 && n != 15'd8) r = R_SIZE;
                else if ((p1 & ~mask) != 32'd0) r = R_FIELD;
                else if (cq && (p1 & 32'h06287fc3) != 32'd0) r = R_GFX;
                else if (p.pw[2] != 32'd0 || p.pw[4] != 32'd0) r = R_FIELD;
                else if (p6 > 32'hffff) r = R_FIELD;
                else if (bytes > (41'h100_0000_0000 - base)) r = R_FIELD;
                else if (n == 15'd8 && (p.pw[6][31:18] != 14'd0 || p.pw[6][13]))
                    r = R_FIELD;
            end
            OP_63, OP_64, OP_9F: begin
                if (op != OP_63 && cq) r = R_GFX;
                else if (n != 15'd5) r = R_SIZE;
                else r = (p1[1:0] == 2'd0 && p.pw[2] == 32'h80000000 &&
                          p.pw[3] <= 32'h3fff) ? R_OK : R_FIELD;
            end
            OP_69, OP_76, OP_79, OP_7A: begin
                off = p1 & ~32'h70000000;
                if (op != OP_76 && cq) r = R_GFX;
                else if (n < 15'd3) r = R_SIZE;
                else if (op == OP_7A && !(p1[31:28] == 4'd0 ||
                         (n == 15'd3 && p1 == 32'h20000243))) r = R_FIELD;
                else if (p1 == 32'hffffffff) r = R_FIELD;
                else if (off > 32'hffff) r = R_FIELD;
                else r = ({2'd0, n} - 17'd2 <= 17'h10000 - off[16:0]) ? R_OK : R_FIELD;
            end
            OP_81: begin
                if (cq) r = R_GFX;
                else r = (p1 <= 32'hbffc && p1[1:0] == 2'd0 &&
                          ({1'b0, n} - 16'd2 <= 16'h3000 - {2'd0, p1[15:2]}))
                         ? R_OK : R_FIELD;
            end
            OP_83: begin
                if (cq) r = R_GFX;
                else if (n != 15'd5) r = R_SIZE;
                else r = (p1 <= 32'hbffc && p1[1:0] == 2'd0 &&
                          p.pw[1] <= 32'h3000 - {18'd0, p1[15:2]}) ? R_OK : R_FIELD;
            end
            OP_37: begin
                d = p1[11:8];
                if (n < 15'd5) r = R_SIZE;
                else if ((p1 & ~32'h00110f00) != 32'd0) r = R_FIELD;
                else if (!(d == 4'd1 || d == 4'd2 || (cq && d == 4'd5))) r = R_FIELD;
                else r = (p.pw[1][1:0] == 2'd0) ? R_OK : R_FIELD;
            end
            OP_40: begin
                if (n != 15'd6) r = R_SIZE;
                else if ((p1 & ~32'h40110f0f) != 32'd0) r = R_FIELD;
                else begin
                    // The selector {p1[3:0], p1[30]} is 5 bits wide.
                    if (p1[11:8] != 4'd1 && p1[11:8] != 4'd2) r = R_FIELD;
                    else if (!({p1[3:0], p1[30]} == 5'd2 || {p1[3:0], p1[30]} == 5'd4 ||
                               {p1[3:0], p1[30]} == 5'd5 ||
                               {p1[3:0], p1[30]} == 5'd10 ||
                               {p1[3:0], p1[30]} == 5'd11)) r = R_FIELD;
                    else if ({p1[3:0], p1[30]} >= 5'd10 &&
                             !(!p1[16] && p.pw[2] == 32'd0)) r = R_FIELD;
                end
            end
            OP_50: begin
                s = {p6[28], p6[26], p1[30:29]};
                d = {p6[29], p6[27], p1[21:20]};
                if (n != 15'd7) r = R_SIZE;
                else if ((p1 & ~32'he0300001) != 32'd0) r = R_FIELD;
                else if (!(d == 4'd0 || d == 4'd3)) r = R_FIELD;
                else if (!(s == 4'd0 || s == 4'd3 || s == 4'd2)) r = R_FIELD;
                else if (s == 4'd2 && p.pw[2] != 32'd0) r = R_FIELD;
            end
            default: r = R_UNSUP;
        endcase
        return r;
    endfunction

    function automatic logic f_supp(input logic [7:0] op);
        logic ok;
        case (op)
            OP_11, OP_12, OP_13, OP_15, OP_16, OP_26, OP_2A, OP_2D, OP_2F,
            OP_35, OP_37, OP_40, OP_42, OP_46, OP_50, OP_58, OP_63, OP_64,
            OP_69, OP_76, OP_79, OP_7A, OP_81, OP_83, OP_9F: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    logic [2:0] w_r;
    logic [31:0] w_h;
    logic [7:0]  w_op;
    logic [5:0]  w_sub;

    always_comb begin
        w_h   = i_pkt.header;
        w_op  = w_h[15:8];
        w_sub = w_h[7:2];
        if (i_pkt.count < 15'd2) w_r = R_HDR;
        else if (w_h[31:30] != 2'b11) w_r = R_HDR;
        else if (i_pkt.count != {1'b0, w_h[29:16]} + 15'd2) w_r = R_HDR;
        else if (w_op == OP_NOP) begin
            if (!(w_sub == 6'h00 || w_sub == 6'h06 || w_sub == 6'h09 ||
                  w_sub == 6'h0b || w_sub == 6'h0c || w_sub == 6'h17 ||
                  w_sub == 6'h1a)) w_r = R_UNSUP;
            else w_r = f_nop(i_pkt);
        end else if (!f_supp(w_op)) w_r = R_UNSUP;
        else if (!(w_h[7:0] == 8'd0 || (w_op == OP_11 && w_h[7:0] == 8'd2)))
            w_r = R_UNSUP;
        else w_r = f_op(i_pkt);
    end

    assign o_pop = i_pkt_valid && (!o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (o_pop) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_accepted <= (w_r == R_OK);
            o_reason   <= w_r;
            o_opcode   <= w_op;
        end
    end

endmodule
`default_nettype wire

### design/gpu_command_packet_validator.sv
// A finished packet's record is registered in the queue, then its verdict in
// the check output register. Throughput: one word per cycle; the front keeps
// taking words while the queue of finished packets has room.
// The two-entry queue between front and check stage lets each side stall
// on its own. Reset (synchronous, active low) clears counters, flags, the
// queue and the output valid; compute_queue resets to graphics.
`timescale 1ns / 1ps
`default_nettype none
module gpu_command_packet_validator
    import gcpv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_compute_queue,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_word,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_accepted,
    output logic [2:0]       o_reason,
    output logic [7:0]       o_opcode
);

    // Queue select register for the block.
    logic r_cq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cq <= 1'b0;
        else if (i_cfg_we) r_cq <= i_cfg_compute_queue;
    end

    t_packet w_pkt_in;
    t_packet w_pkt_out;
    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_qvalid;
    logic    w_acc;

    // Words are refused whenever the queue of finished packets is full.
    assign o_stall = w_full;
    assign w_acc   = i_valid && !w_full;

    gcpv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (i_word),
        .i_last     (i_last),
        .i_cq       (r_cq),
        .i_accept   (w_acc),
        .o_pkt      (w_pkt_in),
        .o_pkt_valid(w_push)
    );

    gcpv_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_pkt_in),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_data (w_pkt_out),
        .o_valid(w_qvalid)
    );

    gcpv_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (w_pkt_out),
        .i_pkt_valid(w_qvalid),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_accepted (o_accepted),
        .o_reason   (o_reason),
        .o_opcode   (o_opcode)
    );

endmodule
`default_nettype wire

### design/gcpv_checker.sv
// Port checker for the command packet validator, bound to the top level.
// Uses gcpv_pkg for the reason codes.
`timescale 1ns / 1ps
`default_nettype none
module gcpv_checker
    import gcpv_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_accepted,
    input wire logic [2:0] o_reason,
    input wire logic [7:0] o_opcode
);

    a_ok_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_accepted == (o_reason == R_OK)))
        else $error("accepted disagrees with reason");

    a_reason_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reason <= R_FIELD))
        else $error("reason out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reason) && $stable(o_opcode))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind gpu_command_packet_validator gcpv_checker u_gcpv_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_accepted(o_accepted),
    .o_reason  (o_reason),
    .o_opcode  (o_opcode)
);
`default_nettype wire

### sim/testbench.sv
// Testbench for the command packet validator: directed packets from a stimulus
// array, then random packets, each verdict checked against an in-bench predictor.
// Depends on gcpv_pkg and gpu_command_packet_validator.
`timescale 1ns / 1ps
module testbench;
    import gcpv_pkg::*;

    // Clock and block ports. Every input starts at a known value.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_compute_queue = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_word = '0;
    logic        i_last = 1'b0;
    logic        i_stall = 1'b1;
    logic        o_stall;
    logic        o_valid;
    logic        o_accepted;
    logic [2:0]  o_reason;
    logic [7:0]  o_opcode;

    always #6 i_clk = ~i_clk;

    gpu_command_packet_validator DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_compute_queue (i_cfg_compute_queue),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_word              (i_word),
        .i_last              (i_last),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_accepted          (o_accepted),
        .o_reason            (o_reason),
        .o_opcode            (o_opcode)
    );

    // One expected verdict, as the block should report it.
    typedef struct packed {
        logic       accepted;
        logic [2:0] reason;
        logic [7:0] opcode;
    } t_verdict;

    t_verdict pending_verdicts[$];
    int       error_count = 0;

    // Knobs shared by the sender, the receiver and the main sequence.
    bit calm_phase = 1'b0;     // no idling on either side while set
    bit hold_output = 1'b0;    // receiver holds off for a long stretch once

    // Predictor state: a copy of what the block keeps for the packet in flight.
    logic [31:0] pkt_header;
    logic [31:0] pkt_payload[1:7];
    logic [31:0] pkt_final;
    logic [14:0] pkt_count = '0;
    bit          pkt_zero_byte = 1'b0;
    bit          pkt_tail_zero = 1'b1;
    bit          queue_is_compute = 1'b0;

    // Payload word i, or zero outside the held range.
    function automatic logic [31:0] payload_at(int i);
        if (i >= 1 && i <= 7) begin
            return pkt_payload[i];
        end
        return '0;
    endfunction

    function automatic logic [2:0] nop_reason(logic [31:0] h, logic [31:0] n, bit cq);
        logic [5:0] sub;
        sub = h[7:2];
        if (h[1:0] != 2'b00) return R_UNSUP;
        case (sub)
            6'h00: return (payload_at(1)[31:16] == 16'h6875) ? R_FIELD : R_OK;
            6'h09: return (n == 2) ? R_OK : R_SIZE;
            6'h06: begin
                if (cq) return R_GFX;
                if (n != 4) return R_SIZE;
                return (payload_at(3) == 0) ? R_OK : R_FIELD;
            end
            6'h0b: return pkt_zero_byte ? R_OK : R_FIELD;
            6'h17: begin
                if (cq) return R_GFX;
                return (n == 6) ? R_OK : R_SIZE;
            end
            6'h1a: begin
                if (cq) return R_GFX;
                if (n != 3 && n != 5) return R_SIZE;
                if (payload_at(1) > 3) return R_FIELD;
                return pkt_tail_zero ? R_OK : R_FIELD;
            end
            default: return R_OK;
        endcase
    endfunction

    function automatic logic [2:0] opcode_reason(logic [31:0] h, logic [7:0] op,
                                                 logic [31:0] n, bit cq);
        logic [31:0] p1, off, mask, s, d, et, ei;
        logic [63:0] base, bytes;
        p1 = payload_at(1);
        case (op)
            OP_11: begin
                if (n != 4) return R_SIZE;
                if (!(p1 == 1 && payload_at(2)[2:0] == 0 && payload_at(3) <= 32'hffff))
                    return R_FIELD;
                if (h[1] == 1'b0 && cq) return R_GFX;
                return R_OK;
            end
            OP_12, OP_2A: begin
                if (cq) return R_GFX;
                if (n != 2) return R_SIZE;
                if (op == OP_12) return (p1[31:4] == 0) ? R_OK : R_FIELD;
                return (p1 <= 3) ? R_OK : R_FIELD;
            end
            OP_13, OP_2F: begin
                if (cq) return R_GFX;
                return (n == 2) ? R_OK : R_SIZE;
            end
            OP_26: begin
                if (cq) return R_GFX;
                return (n == 3) ? R_OK : R_SIZE;
            end
            OP_2D: begin
                if (cq) return R_GFX;
                if (n != 3) return R_SIZE;
                return ((payload_at(2) & ~32'h20) == 2) ? R_OK : R_FIELD;
            end
            OP_35: begin
                if (cq) return R_GFX;
                if (n != 5) return R_SIZE;
                if (payload_at(3) > p1) return R_FIELD;
                return ((payload_at(4) & ~32'h20) == 0) ? R_OK : R_FIELD;
            end
            OP_15: begin
                if (n != 5) return R_SIZE;
                return ((payload_at(4) & ~32'h8000) == 32'h41) ? R_OK : R_FIELD;
            end
            OP_16: begin
                if (n != 3 && n != 4) return R_SIZE;
                return ((pkt_final & ~32'h8000) == 32'h41) ? R_OK : R_FIELD;
            end
            OP_42: begin
                if (n != 2) return R_SIZE;
                return (p1 == 0) ? R_OK : R_FIELD;
            end
            OP_46: begin
                et = p1 & 32'h3f;
                ei = (p1 >> 8) & 32'h7;
                if ((p1 & ~32'h73f) != 0) return R_FIELD;
                if (et == 32'h07 || et == 32'h0f || et == 32'h10) begin
                    if (n != 2) return R_SIZE;
                    if (ei != 4) return R_FIELD;
                    if (et != 32'h07 && cq) return R_GFX;
                    return R_OK;
                end
                if (et == 32'h16 || et == 32'h31 || et == 32'h2a || et == 32'h2c ||
                    et == 32'h2e) begin
                    if (cq) return R_GFX;
                    if (n != 2) return R_SIZE;
                    return (ei == 0 || ei == 7) ? R_OK : R_FIELD;
                end
                return R_FIELD;
            end
            OP_58: begin
                if (n != 7 && n != 8) return R_SIZE;
                mask = (n == 8) ? 32'h86287fc3 : 32'hfeecfffb;
                if ((p1 & ~mask) != 0) return R_FIELD;
                if (cq && (p1 & 32'h06287fc3) != 0) return R_GFX;
                if (payload_at(3) != 0 || payload_at(5) != 0) return R_FIELD;
                if (payload_at(6) > 32'hffff) return R_FIELD;
                base  = {24'd0, payload_at(4), 8'd0};
                bytes = {24'd0, payload_at(2), 8'd0};
                if (bytes > (64'd1 << 40) - base) return R_FIELD;
                if (n == 8) begin
                    if ((payload_at(7) & ~32'h3ffff) != 0) return R_FIELD;
                    if ((payload_at(7) & 32'h2000) != 0) return R_FIELD;
                end
                return R_OK;
            end
            OP_63, OP_64, OP_9F: begin
                if (op != OP_63 && cq) return R_GFX;
                if (n != 5) return R_SIZE;
                return (p1[1:0] == 0 && payload_at(3) == 32'h80000000 &&
                        payload_at(4) <= 32'h3fff) ? R_OK : R_FIELD;
            end
            OP_69, OP_76, OP_79, OP_7A: begin
                if (op != OP_76 && cq) return R_GFX;
                if (n < 3) return R_SIZE;
                if (op == OP_7A && !(p1[31:28] == 0 || (n == 3 && p1 == 32'h20000243)))
                    return R_FIELD;
                if (p1 == 32'hffffffff) return R_FIELD;
                off = p1 & ~32'h70000000;
                if (off > 32'hffff) return R_FIELD;
                return (n - 2 <= 32'h10000 - off) ? R_OK : R_FIELD;
            end
            OP_81: begin
                if (cq) return R_GFX;
                return (p1 <= 32'hbffc && p1[1:0] == 0 && n - 2 <= 32'h3000 - p1 / 4)
                       ? R_OK : R_FIELD;
            end
            OP_83: begin
                if (cq) return R_GFX;
                if (n != 5) return R_SIZE;
                return (p1 <= 32'hbffc && p1[1:0] == 0 &&
                        payload_at(2) <= 32'h3000 - p1 / 4) ? R_OK : R_FIELD;
            end
            OP_37: begin
                if (n < 5) return R_SIZE;
                if ((p1 & ~32'h00110f00) != 0) return R_FIELD;
                d = (p1 >> 8) & 32'hf;
                if (!(d == 1 || d == 2 || (cq && d == 5))) return R_FIELD;
                return (payload_at(2)[1:0] == 0) ? R_OK : R_FIELD;
            end
            OP_40: begin
                if (n != 6) return R_SIZE;
                if ((p1 & ~32'h40110f0f) != 0) return R_FIELD;
                s = ((p1 & 32'hf) << 1) | ((p1 >> 30) & 1);
                d = ((p1 >> 8) & 32'hf) << 1;
                if (d != 2 && d != 4) return R_FIELD;
                if (!(s == 2 || s == 4 || s == 5 || s == 10 || s == 11)) return R_FIELD;
                if (s >= 10 && !(p1[16] == 0 && payload_at(3) == 0)) return R_FIELD;
                return R_OK;
            end
            OP_50: begin
                s = ((p1 >> 29) & 3) | ((payload_at(6) >> 24) & 4) |
                    ((payload_at(6) >> 25) & 8);
                d = ((p1 >> 20) & 3) | ((payload_at(6) >> 25) & 4) |
                    ((payload_at(6) >> 26) & 8);
                if (n != 7) return R_SIZE;
                if ((p1 & ~32'he0300001) != 0) return R_FIELD;
                if (!(d == 0 || d == 3)) return R_FIELD;
                if (!(s == 0 || s == 3 || s == 2)) return R_FIELD;
                if (s == 2 && payload_at(3) != 0) return R_FIELD;
                return R_OK;
            end
            default: return R_UNSUP;
        endcase
    endfunction

    // The checks run in a fixed order; the first failing one names the reason.
    function automatic logic [2:0] packet_reason();
        logic [31:0] h, n;
        logic [7:0]  op;
        bit          nop_ok;
        h  = pkt_header;
        n  = {17'd0, pkt_count};
        op = h[15:8];
        if (n < 2) return R_HDR;
        if (h[31:30] != 2'b11) return R_HDR;
        if (n != {18'd0, h[29:16]} + 2) return R_HDR;
        if (op == OP_NOP) begin
            nop_ok = h[7:2] inside {6'h00, 6'h06, 6'h09, 6'h0b, 6'h0c, 6'h17, 6'h1a};
            if (!nop_ok) return R_UNSUP;
            return nop_reason(h, n, queue_is_compute);
        end
        if (!(op inside {OP_11, OP_12, OP_13, OP_15, OP_16, OP_26, OP_2A, OP_2D, OP_2F,
                         OP_35, OP_37, OP_40, OP_42, OP_46, OP_50, OP_58, OP_63, OP_64,
                         OP_69, OP_76, OP_79, OP_7A, OP_81, OP_83, OP_9F}))
            return R_UNSUP;
        if (!(h[7:0] == 0 || (op == OP_11 && h[7:0] == 8'h02))) return R_UNSUP;
        return opcode_reason(h, op, n, queue_is_compute);
    endfunction

    // Advances the predictor by one accepted word. Returns 1 with the verdict
    // when the word closes a packet.
    function automatic bit absorb_word(logic [31:0] w, logic l, output t_verdict v);
        logic [2:0] r;
        if (pkt_count == 0) begin
            pkt_header = w;
        end else begin
            if (pkt_count <= 7) pkt_payload[pkt_count] = w;
            if (w[7:0] == 0 || w[15:8] == 0 || w[23:16] == 0 || w[31:24] == 0)
                pkt_zero_byte = 1'b1;
            if (pkt_count >= 2 && w != 0) pkt_tail_zero = 1'b0;
        end
        pkt_final = w;
        if (pkt_count != COUNT_MAX) pkt_count = pkt_count + 1'b1;
        if (!l) return 1'b0;
        r = packet_reason();
        v = '{accepted: (r == R_OK), reason: r, opcode: pkt_header[15:8]};
        pkt_count = '0;
        pkt_zero_byte = 1'b0;
        pkt_tail_zero = 1'b1;
        return 1'b1;
    endfunction

    // Offers one word after a random gap and waits for the block to take it.
    // On the closing word the verdict is queued: the typed one if given,
    // otherwise the predicted one.
    task automatic offer_word(logic [31:0] w, logic l, bit typed, logic [2:0] typed_r);
        int       gap;
        t_verdict v;
        gap = calm_phase ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        i_last  <= l;
        do @(posedge i_clk); while (o_stall);
        if (absorb_word(w, l, v)) begin
            if (typed) begin
                v.reason = typed_r;
                v.accepted = (typed_r == R_OK);
            end
            pending_verdicts.push_back(v);
        end
    endtask

    task automatic offer_packet(logic [31:0] words[$], bit typed, logic [2:0] typed_r);
        foreach (words[i]) begin
            offer_word(words[i], i == words.size() - 1, typed, typed_r);
        end
    endtask

    // Writes the queue type once every verdict is out and the check stage
    // has had time to settle.
    task automatic set_queue_type(bit compute);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_compute_queue <= compute;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        queue_is_compute = compute;
    endtask

    function automatic logic [31:0] make_header(int n, logic [7:0] op, logic [7:0] low);
        logic [13:0] len;
        len = 14'(n - 2);
        return {2'b11, len, op, low};
    endfunction

    // Random payload word, biased toward the values and masks that the checks
    // look at so that deep checks are reached often.
    function automatic logic [31:0] pick_payload();
        logic [31:0] masks[10];
        logic [31:0] picks[14];
        masks = '{32'h73f, 32'h00110f00, 32'h40110f0f, 32'he0300001, 32'h86287fc3,
                  32'hfeecfffb, 32'hbffc, 32'hf, 32'h3, 32'hffff};
        picks = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h41, 32'h8041, 32'h80000000,
                  32'h20000243, 32'hffffffff, 32'h407, 32'h40f, 32'h410, 32'h716,
                  32'h22};
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom & masks[$urandom_range(0, 9)];
            default: return picks[$urandom_range(0, 13)];
        endcase
    endfunction

    // Builds one random packet: mostly well formed with random content, the
    // rest with a broken header, wrong length or an unknown opcode.
    function automatic void build_random_packet(output logic [31:0] words[$]);
        logic [7:0] ops[26];
        logic [5:0] subs[7];
        logic [7:0] op, low;
        int         n, stated;
        ops  = '{OP_NOP, OP_11, OP_12, OP_13, OP_15, OP_16, OP_26, OP_2A, OP_2D, OP_2F,
                 OP_35, OP_37, OP_40, OP_42, OP_46, OP_50, OP_58, OP_63, OP_64, OP_69,
                 OP_76, OP_79, OP_7A, OP_81, OP_83, OP_9F};
        subs = '{6'h00, 6'h06, 6'h09, 6'h0b, 6'h0c, 6'h17, 6'h1a};
        words = {};
        op = ($urandom_range(0, 19) == 0) ? 8'($urandom) : ops[$urandom_range(0, 25)];
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(2, 9);
        low = 8'h00;
        if (op == OP_NOP) low = {subs[$urandom_range(0, 6)], 2'b00};
        if (op == OP_11 && $urandom_range(0, 1)) low = 8'h02;
        if ($urandom_range(0, 19) == 0) low = 8'($urandom);
        stated = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 10) : n;
        words.push_back(make_header(stated, op, low));
        if ($urandom_range(0, 24) == 0) words[0] = $urandom;
        for (int i = 1; i < n; i++) begin
            // Zero tails keep the all-zero-tail flag reachable.
            words.push_back((i >= 2 && $urandom_range(0, 3) == 0) ? 32'h0 : pick_payload());
        end
    endfunction

    // Directed packets. Rows marked typed carry a verdict that can be read off
    // at a glance; the others are left to the predictor.
    typedef struct {
        logic [31:0] words[8];
        int          n;
        bit          typed;
        logic [2:0]  reason;
    } t_directed_row;

    t_directed_row directed_rows[20];

    initial begin
        directed_rows = '{
            // Short packet: the header alone.
            '{'{32'hc0001000, 0, 0, 0, 0, 0, 0, 0}, 1, 1, R_HDR},
            // Wrong packet type in the top bits.
            '{'{32'h80001000, 0, 0, 0, 0, 0, 0, 0}, 2, 1, R_HDR},
            // Stated length does not match the words sent.
            '{'{32'hc0011000, 0, 0, 0, 0, 0, 0, 0}, 2, 1, R_HDR},
            '{'{32'h00000000, 0, 0, 0, 0, 0, 0, 0}, 2, 1, R_HDR},
            '{'{32'hffffffff, 32'hffffffff, 0, 0, 0, 0, 0, 0}, 2, 1, R_HDR},
            // Opcode outside the support list.
            '{'{32'hc0000100, 0, 0, 0, 0, 0, 0, 0}, 2, 1, R_UNSUP},
            // Plain NOP, then a NOP subtype that is not supported.
            '{'{32'hc0001000, 32'h0, 0, 0, 0, 0, 0, 0}, 2, 1, R_OK},
            '{'{32'hc0001004, 32'h0, 0, 0, 0, 0, 0, 0}, 2, 1, R_UNSUP},
            '{'{32'hc0001000, 32'h68751234, 0, 0, 0, 0, 0, 0}, 2, 1, R_FIELD},
            // Event write with an event type that has no check.
            '{'{32'hc0004600, 32'h00000001, 0, 0, 0, 0, 0, 0}, 2, 1, R_FIELD},
            // Register write: indirect marker and an offset past the window.
            '{'{32'hc0016900, 32'hffffffff, 32'h5, 0, 0, 0, 0, 0}, 3, 1, R_FIELD},
            '{'{32'hc0016900, 32'h00010000, 32'h5, 0, 0, 0, 0, 0}, 3, 1, R_FIELD},
            '{'{32'hc0004200, 32'h0, 0, 0, 0, 0, 0, 0}, 2, 1, R_OK},
            '{'{32'hc0014200, 32'h0, 32'h0, 0, 0, 0, 0, 0}, 3, 1, R_SIZE},
            // The rest go to the predictor.
            '{'{32'hc0065800, 32'h86287fc3, 32'h1, 0, 32'h2, 0, 32'hffff, 32'h1fff}, 8, 0, R_OK},
            '{'{32'hc0055000, 32'he0000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0}, 7, 0, R_OK},
            '{'{32'hc0044000, 32'h40000105, 0, 0, 0, 0, 0, 0}, 6, 0, R_OK},
            '{'{32'hc0033700, 32'h00010100, 32'h4, 32'h0, 32'h0, 0, 0, 0}, 5, 0, R_OK},
            '{'{32'hc0031500, 32'h0, 32'h0, 32'h0, 32'h8041, 0, 0, 0}, 5, 0, R_OK},
            '{'{32'hc0021102, 32'h1, 32'h8, 32'hffff, 0, 0, 0, 0}, 4, 0, R_OK}
        };
    end

    // Receiver: random stall before each verdict, a long hold-off once, and a
    // field-by-field check of every verdict against the oldest expectation.
    initial begin
        int       wait_cycles;
        t_verdict want;
        forever begin
            wait_cycles = calm_phase ? 0 : $urandom_range(0, 8);
            if (hold_output) begin
                wait_cycles = 400;
                hold_output = 1'b0;
            end
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict with none expected: accepted %0d reason %0d opcode %h",
                         $time, o_accepted, o_reason, o_opcode);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_accepted !== want.accepted) begin
                    $display("%0t: accepted expected %0d actual %0d", $time,
                             want.accepted, o_accepted);
                    error_count++;
                end
                if (o_reason !== want.reason) begin
                    $display("%0t: reason expected %0d actual %0d", $time,
                             want.reason, o_reason);
                    error_count++;
                end
                if (o_opcode !== want.opcode) begin
                    $display("%0t: opcode expected %h actual %h", $time,
                             want.opcode, o_opcode);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed packets, then random phases under both
    // queue types.
    initial begin
        logic [31:0] words[$];
        int          sent;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_queue_type(1'b0);
        foreach (directed_rows[r]) begin
            words = {};
            for (int i = 0; i < directed_rows[r].n; i++) begin
                words.push_back(directed_rows[r].words[i]);
            end
            offer_packet(words, directed_rows[r].typed, directed_rows[r].reason);
        end

        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            set_queue_type(phase[0]);
            // The second phase starts with the output held off while the
            // sender keeps offering words back to back.
            if (phase == 1) begin
                hold_output = 1'b1;
                calm_phase = 1'b1;
            end
            if (phase == 3) calm_phase = 1'b1;
            while (sent < 250 * (phase + 1)) begin
                build_random_packet(words);
                offer_packet(words, 1'b0, R_OK);
                sent += words.size();
                if (phase == 1 && sent > 250 + 60) calm_phase = 1'b0;
            end
            calm_phase = 1'b0;
        end

        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
